>>> src/rkcb_pkg.sv
// shared types, constants and helpers of the border-renormalising convolution block
package rkcb_pkg;

    localparam int MAX_HEIGHT = 4096;
    localparam int SUM_W      = 48;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ORDER  = 2'd2;
    localparam logic [1:0] CFG_KSUM   = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         tap_index;
        logic signed [23:0] tap_value;
        logic [15:0]        in_red;
        logic [15:0]        in_green;
        logic [15:0]        in_blue;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  out_column;
        logic [11:0] out_row;
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic        clipped;
        logic        zero_divisor;
        logic        frame_last;
    } t_out_item;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TAPS  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_DIVS  = 6'b001000,
        S_DIVW  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // q8 product truncated toward zero to an integer
    function automatic logic signed [32:0] trunc_q8(input logic signed [40:0] p);
        logic signed [40:0] t;
        t = p[40] ? (p + 41'sd255) : p;
        return 33'(t >>> 8);
    endfunction

endpackage

>>> src/rkcb_ram.sv
// generic simple dual-port ram with registered read
module rkcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/rkcb_div.sv
// iterative 16-bit quotient divider with saturation, one bit per cycle
module rkcb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rkcb_pkg::SUM_W-1:0] i_num,
    input  logic [31:0]                i_den,
    output logic                       o_done,
    output logic [15:0]                o_quot,
    output logic                       o_clip
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [15:0] r_low;
    logic [15:0] r_q;
    logic        r_clip;
    logic [31:0] r_den;
    logic [32:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_low[15]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_den <= i_den;
                // quotient of num*256/den overflows 16 bits when num >= den*256
                if (i_num >= {8'd0, i_den, 8'd0}) begin
                    r_q    <= 16'hFFFF;
                    r_clip <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_clip <= 1'b0;
                    r_done <= 1'b0;
                    r_rem  <= 32'(i_num >> 8);
                    r_low  <= {i_num[7:0], 8'd0};
                    r_cnt  <= 5'd16;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
                r_low <= {r_low[14:0], 1'b0};
                r_q   <= {r_q[14:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // done stays high until the next start
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_clip = r_clip;
endmodule

>>> src/rgb_kernel_convolution_border_renorm_unit.sv
// top level of the rgb kernel convolution with border renormalisation
//
// input channel (i_in_valid / o_in_stall, payload i_in_data): each item is a
// tap load, an image pixel in raster order, or a flush that drains one pending
// output pixel once the whole frame is in
// output channel (o_out_valid / i_out_stall, payload o_out_data): one item per
// filtered pixel, with its column, row, channels and flags
// configuration: i_cfg_we / i_cfg_index / i_cfg_data, written while idle;
// a geometry write restarts the frame
// processing: an item that gives no result leaves the block idle for the next; one
// that gives a result holds off further input until that result is loaded into the
// output register, through the tap loop of one line-store read and one mac per channel
// per cycle, then the mac drain and, for a nonzero divisor, one divider per channel
// latency: output pixel k leaves with input pixel k + order*width + order
// reset: positions, tap valid bits and control clear; the line store is not
// cleared since every entry is written in the frame before it is read
// a stalled result sits in the output register while the next input is taken;
// a further result waits until that register empties
module rgb_kernel_convolution_border_renorm_unit #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_KERNEL_SIDE = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  rkcb_pkg::t_in_item   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output rkcb_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    localparam int SD        = MAX_KERNEL_SIDE * MAX_WIDTH;
    localparam int AW        = $clog2(SD);
    localparam int OFW       = AW + 2;
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int XW        = WW + 2;
    localparam int PW        = $clog2(MAX_WIDTH * rkcb_pkg::MAX_HEIGHT + 1);
    localparam int TAP_COUNT = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int TW        = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int ORD_LIM   = (MAX_KERNEL_SIDE - 1) / 2;
    localparam int SW        = rkcb_pkg::SUM_W;

    // configuration registers
    logic [10:0]        r_image_width;
    logic [12:0]        r_image_height;
    logic [1:0]         r_kernel_order;
    logic signed [31:0] r_full_kernel_sum;

    rkcb_pkg::t_state r_state;

    // frame positions and store addresses
    logic [PW-1:0] r_in_pos;
    logic [PW-1:0] r_out_pos;
    logic [AW-1:0] r_wr_addr;
    logic [AW-1:0] r_out_addr;
    logic [WW-1:0] r_col;
    logic [11:0]   r_row;

    // tap loop
    logic [3:0]            r_dy;
    logic [3:0]            r_dx;
    logic [TW-1:0]         r_ti;
    logic signed [OFW-1:0] r_off;
    logic                  r_full;
    logic                  r_s1_vld;
    logic                  r_s1_in;
    logic                  r_s2_vld;
    logic                  r_cvld_q;
    logic signed [40:0]    r_prod_r, r_prod_g, r_prod_b;
    logic signed [23:0]    r_tap2;
    logic signed [SW-1:0]  r_acc_r, r_acc_g, r_acc_b;
    logic signed [31:0]    r_tsum;
    logic [TAP_COUNT-1:0]  r_coef_vld;

    // result
    logic        r_zero;
    logic [15:0] r_q_r, r_q_g, r_q_b;
    logic        r_clip;
    logic        r_out_vld;
    rkcb_pkg::t_out_item r_out;

    // effective geometry
    logic [WW-1:0] w_w;
    logic [12:0]   w_h;
    logic [2:0]    w_o;
    logic [3:0]    w_side;
    logic [PW-1:0] w_n;
    logic [PW-1:0] w_lag;

    always_comb begin
        if (r_image_width == 11'd0) begin
            w_w = WW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_image_width);
        end
        if (r_image_height == 13'd0) begin
            w_h = 13'd1;
        end else if (32'(r_image_height) > rkcb_pkg::MAX_HEIGHT) begin
            w_h = 13'(rkcb_pkg::MAX_HEIGHT);
        end else begin
            w_h = r_image_height;
        end
        w_o = (32'(r_kernel_order) > ORD_LIM) ? 3'(ORD_LIM) : {1'b0, r_kernel_order};
    end

    assign w_side = {w_o, 1'b1};
    assign w_n    = PW'(32'(w_w) * 32'(w_h));
    assign w_lag  = PW'(32'(w_o) * 32'(w_w) + 32'(w_o));

    // item decode
    logic w_idle, w_acc, w_load, w_pix_ok, w_emit;
    logic [PW:0] w_need;

    assign w_idle   = (r_state == rkcb_pkg::S_IDLE);
    assign w_acc    = w_idle && i_in_valid;
    assign w_load   = w_acc && (i_in_data.opcode == rkcb_pkg::OP_LOAD)
                      && (32'(i_in_data.tap_index) < TAP_COUNT);
    assign w_pix_ok = w_acc && (i_in_data.opcode == rkcb_pkg::OP_PIXEL) && (r_in_pos < w_n);
    assign w_need   = {1'b0, r_out_pos} + {1'b0, w_lag};
    always_comb begin
        w_emit = 1'b0;
        if (w_pix_ok && (r_out_pos < w_n) && ({1'b0, r_in_pos} >= w_need)) begin
            w_emit = 1'b1;
        end
        if (w_acc && (i_in_data.opcode == rkcb_pkg::OP_FLUSH)
            && (r_in_pos >= w_n) && (r_out_pos < w_n)) begin
            w_emit = 1'b1;
        end
    end

    // tap address and in-image test
    logic signed [OFW-1:0] w_a;
    logic [AW-1:0]         w_raddr;
    logic signed [14:0]    w_yy;
    logic signed [XW-1:0]  w_xx;
    logic                  w_in;
    logic                  w_last;

    always_comb begin
        w_a = $signed(OFW'(r_out_addr)) + r_off;
        if (w_a < 0) begin
            w_raddr = AW'(w_a + $signed(OFW'(SD)));
        end else if (w_a >= $signed(OFW'(SD))) begin
            w_raddr = AW'(w_a - $signed(OFW'(SD)));
        end else begin
            w_raddr = AW'(w_a);
        end
    end

    assign w_yy   = $signed(15'(r_row)) + $signed(15'(r_dy)) - $signed(15'(w_o));
    assign w_xx   = $signed(XW'(r_col)) + $signed(XW'(r_dx)) - $signed(XW'(w_o));
    assign w_in   = (w_yy >= 0) && (w_yy < $signed(15'(w_h)))
                    && (w_xx >= 0) && (w_xx < $signed(XW'(w_w)));
    assign w_last = (r_dy == w_side - 4'd1) && (r_dx == w_side - 4'd1);

    // memories
    logic [47:0]        w_px;
    logic signed [23:0] w_coef;

    rkcb_ram #(.WIDTH(48), .DEPTH(SD)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_pix_ok),
        .i_waddr (r_wr_addr),
        .i_wdata ({i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue}),
        .i_raddr (w_raddr),
        .o_rdata (w_px)
    );

    rkcb_ram #(.WIDTH(24), .DEPTH(TAP_COUNT)) u_coef_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (TW'(i_in_data.tap_index)),
        .i_wdata (i_in_data.tap_value),
        .i_raddr (r_ti),
        .o_rdata (w_coef)
    );

    logic signed [23:0] w_tap;
    assign w_tap = r_cvld_q ? w_coef : 24'sd0;

    // dividers, one per channel
    logic signed [31:0] w_div;
    logic [31:0]        w_den;
    logic               w_start;
    logic [SW-1:0]      w_num_r, w_num_g, w_num_b;
    logic               w_done_r, w_done_g, w_done_b;
    logic [15:0]        w_q_r, w_q_g, w_q_b;
    logic               w_c_r, w_c_g, w_c_b;

    assign w_div   = r_full ? r_full_kernel_sum : r_tsum;
    assign w_den   = w_div[31] ? 32'(-w_div) : 32'(w_div);
    assign w_start = (r_state == rkcb_pkg::S_DIVS) && (w_div != 32'sd0);
    assign w_num_r = r_acc_r[SW-1] ? SW'(-r_acc_r) : SW'(r_acc_r);
    assign w_num_g = r_acc_g[SW-1] ? SW'(-r_acc_g) : SW'(r_acc_g);
    assign w_num_b = r_acc_b[SW-1] ? SW'(-r_acc_b) : SW'(r_acc_b);

    rkcb_div u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_num(w_num_r),
        .i_den(w_den), .o_done(w_done_r), .o_quot(w_q_r), .o_clip(w_c_r)
    );
    rkcb_div u_div_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_num(w_num_g),
        .i_den(w_den), .o_done(w_done_g), .o_quot(w_q_g), .o_clip(w_c_g)
    );
    rkcb_div u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_num(w_num_b),
        .i_den(w_den), .o_done(w_done_b), .o_quot(w_q_b), .o_clip(w_c_b)
    );

    logic w_out_load;
    logic w_frame_end;
    assign w_out_load  = (r_state == rkcb_pkg::S_OUT) && (!r_out_vld || !i_out_stall);
    assign w_frame_end = ({1'b0, r_out_pos} + {{PW{1'b0}}, 1'b1}) >= {1'b0, w_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= 11'd1024;
            r_image_height    <= 13'd1024;
            r_kernel_order    <= 2'd1;
            r_full_kernel_sum <= 32'sd256;
            r_state           <= rkcb_pkg::S_IDLE;
            r_in_pos          <= '0;
            r_out_pos         <= '0;
            r_wr_addr         <= '0;
            r_out_addr        <= '0;
            r_col             <= '0;
            r_row             <= '0;
            r_coef_vld        <= '0;
            r_s1_vld          <= 1'b0;
            r_s2_vld          <= 1'b0;
            r_out_vld         <= 1'b0;
        end else begin
            // configuration; geometry writes restart the frame
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rkcb_pkg::CFG_WIDTH:  r_image_width     <= i_cfg_data[10:0];
                    rkcb_pkg::CFG_HEIGHT: r_image_height    <= i_cfg_data[12:0];
                    rkcb_pkg::CFG_ORDER:  r_kernel_order    <= i_cfg_data[1:0];
                    rkcb_pkg::CFG_KSUM:   r_full_kernel_sum <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index != rkcb_pkg::CFG_KSUM) begin
                    r_in_pos   <= '0;
                    r_out_pos  <= '0;
                    r_wr_addr  <= '0;
                    r_out_addr <= '0;
                    r_col      <= '0;
                    r_row      <= '0;
                end
            end

            if (w_load) begin
                r_coef_vld[TW'(i_in_data.tap_index)] <= 1'b1;
            end
            if (w_pix_ok) begin
                r_in_pos  <= r_in_pos + PW'(1);
                r_wr_addr <= (32'(r_wr_addr) == SD - 1) ? '0 : r_wr_addr + AW'(1);
            end

            // mac pipeline: read, multiply, accumulate
            r_s1_vld <= (r_state == rkcb_pkg::S_TAPS);
            r_s1_in  <= w_in;
            r_cvld_q <= r_coef_vld[r_ti];
            r_s2_vld <= r_s1_vld && r_s1_in;
            r_prod_r <= $signed({1'b0, w_px[47:32]}) * w_tap;
            r_prod_g <= $signed({1'b0, w_px[31:16]}) * w_tap;
            r_prod_b <= $signed({1'b0, w_px[15:0]}) * w_tap;
            r_tap2   <= w_tap;
            if (r_s2_vld) begin
                r_acc_r <= r_acc_r + SW'(rkcb_pkg::trunc_q8(r_prod_r));
                r_acc_g <= r_acc_g + SW'(rkcb_pkg::trunc_q8(r_prod_g));
                r_acc_b <= r_acc_b + SW'(rkcb_pkg::trunc_q8(r_prod_b));
                r_tsum  <= r_tsum + 32'(r_tap2);
            end

            // output register drains unless a new result replaces it
            if (r_out_vld && !i_out_stall && !w_out_load) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                rkcb_pkg::S_IDLE: begin
                    if (w_emit) begin
                        r_dy    <= '0;
                        r_dx    <= '0;
                        r_ti    <= '0;
                        r_off   <= -$signed(OFW'(w_lag));
                        r_full  <= 1'b1;
                        r_acc_r <= '0;
                        r_acc_g <= '0;
                        r_acc_b <= '0;
                        r_tsum  <= '0;
                        r_state <= rkcb_pkg::S_TAPS;
                    end
                end
                rkcb_pkg::S_TAPS: begin
                    if (!w_in) begin
                        r_full <= 1'b0;
                    end
                    r_ti <= r_ti + TW'(1);
                    if (r_dx == w_side - 4'd1) begin
                        r_dx  <= '0;
                        r_dy  <= r_dy + 4'd1;
                        r_off <= r_off + $signed(OFW'(w_w)) - $signed(OFW'({w_o, 1'b0}));
                    end else begin
                        r_dx  <= r_dx + 4'd1;
                        r_off <= r_off + $signed(OFW'(1));
                    end
                    if (w_last) begin
                        r_state <= rkcb_pkg::S_DRAIN;
                    end
                end
                rkcb_pkg::S_DRAIN: begin
                    if (!r_s1_vld && !r_s2_vld) begin
                        r_state <= rkcb_pkg::S_DIVS;
                    end
                end
                rkcb_pkg::S_DIVS: begin
                    if (w_div == 32'sd0) begin
                        r_zero  <= 1'b1;
                        r_q_r   <= '0;
                        r_q_g   <= '0;
                        r_q_b   <= '0;
                        r_clip  <= 1'b0;
                        r_state <= rkcb_pkg::S_OUT;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= rkcb_pkg::S_DIVW;
                    end
                end
                rkcb_pkg::S_DIVW: begin
                    if (w_done_r && w_done_g && w_done_b) begin
                        r_q_r   <= w_q_r;
                        r_q_g   <= w_q_g;
                        r_q_b   <= w_q_b;
                        r_clip  <= w_c_r | w_c_g | w_c_b;
                        r_state <= rkcb_pkg::S_OUT;
                    end
                end
                rkcb_pkg::S_OUT: begin
                    if (w_out_load) begin
                        r_out.out_column   <= 10'(r_col);
                        r_out.out_row      <= r_row;
                        r_out.out_red      <= r_q_r;
                        r_out.out_green    <= r_q_g;
                        r_out.out_blue     <= r_q_b;
                        r_out.clipped      <= r_clip;
                        r_out.zero_divisor <= r_zero;
                        r_out.frame_last   <= w_frame_end;
                        r_out_vld          <= 1'b1;
                        r_state            <= rkcb_pkg::S_IDLE;
                        if (w_frame_end) begin
                            r_in_pos   <= '0;
                            r_out_pos  <= '0;
                            r_wr_addr  <= '0;
                            r_out_addr <= '0;
                            r_col      <= '0;
                            r_row      <= '0;
                        end else begin
                            r_out_pos  <= r_out_pos + PW'(1);
                            r_out_addr <= (32'(r_out_addr) == SD - 1) ? '0
                                          : r_out_addr + AW'(1);
                            if (r_col == w_w - WW'(1)) begin
                                r_col <= '0;
                                r_row <= r_row + 12'd1;
                            end else begin
                                r_col <= r_col + WW'(1);
                            end
                        end
                    end
                end
                default: r_state <= rkcb_pkg::S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = !w_idle;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule

>>> bench/rkcb_checker.sv
// scoreboard of the convolution block: follows the channels, predicts every filtered pixel
`timescale 1ns / 1ps

module rkcb_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  rkcb_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  rkcb_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);
    localparam int LINE_DEPTH = 7 * 1024;
    localparam int TAPS       = 49;

    logic [47:0]         pixel_lines [LINE_DEPTH];
    logic signed [23:0]  coef [TAPS];
    int unsigned         in_pos, out_pos;
    logic [10:0]         reg_width;
    logic [12:0]         reg_height;
    logic [1:0]          reg_order;
    logic signed [31:0]  reg_ksum;
    rkcb_pkg::t_out_item pending_pixels [$];

    function automatic int unsigned cur_width();
        if (reg_width == 0) return 1;
        if (reg_width > 1024) return 1024;
        return reg_width;
    endfunction

    function automatic int unsigned cur_height();
        if (reg_height == 0) return 1;
        if (reg_height > rkcb_pkg::MAX_HEIGHT) return rkcb_pkg::MAX_HEIGHT;
        return reg_height;
    endfunction

    // abs of quotient with q8 divisor, saturated
    function automatic logic [15:0] renorm(input longint acc, input longint dv, inout bit clip);
        longint unsigned num, den, q;
        num = (acc < 0) ? -acc : acc;
        den = (dv < 0) ? -dv : dv;
        q = (num * 256) / den;
        if (q > 65535) begin
            clip = 1;
            q = 65535;
        end
        return q[15:0];
    endfunction

    function automatic rkcb_pkg::t_out_item filter_pixel();
        rkcb_pkg::t_out_item res;
        int unsigned w, h, o, side, n, pos, ti;
        longint      r, c, yy, xx, sr, sg, sb, tsum, dv, t;
        logic [47:0] px;
        bit          full, clip;
        w = cur_width();
        h = cur_height();
        o = reg_order;
        side = 2 * o + 1;
        n = w * h;
        pos = out_pos;
        r = pos / w;
        c = pos % w;
        sr = 0; sg = 0; sb = 0; tsum = 0;
        full = 1;
        clip = 0;
        for (int dy = -int'(o); dy <= int'(o); dy++) begin
            for (int dx = -int'(o); dx <= int'(o); dx++) begin
                yy = r + dy;
                xx = c + dx;
                if (yy < 0 || yy >= h || xx < 0 || xx >= w) begin
                    full = 0;
                end else begin
                    ti = (dy + o) * side + (dx + o);
                    t = coef[ti];
                    px = pixel_lines[(yy * w + xx) % LINE_DEPTH];
                    sr += (longint'(px[47:32]) * t) / 256;
                    sg += (longint'(px[31:16]) * t) / 256;
                    sb += (longint'(px[15:0]) * t) / 256;
                    tsum += t;
                end
            end
        end
        dv = full ? longint'(reg_ksum) : tsum;
        res = '0;
        res.out_column = c[9:0];
        res.out_row = r[11:0];
        if (dv == 0) begin
            res.zero_divisor = 1'b1;
        end else begin
            res.out_red = renorm(sr, dv, clip);
            res.out_green = renorm(sg, dv, clip);
            res.out_blue = renorm(sb, dv, clip);
            res.clipped = clip;
        end
        res.frame_last = (pos + 1 >= n);
        out_pos = pos + 1;
        if (out_pos >= n) begin
            out_pos = 0;
            in_pos = 0;
        end
        return res;
    endfunction

    assign o_pending = pending_pixels.size();

    always @(posedge i_clk) begin
        rkcb_pkg::t_out_item exp_px;
        int unsigned n, lag;
        if (!i_rst_n) begin
            foreach (coef[k]) coef[k] = '0;
            in_pos = 0;
            out_pos = 0;
            reg_width = 11'd1024;
            reg_height = 13'd1024;
            reg_order = 2'd1;
            reg_ksum = 32'sd256;
            pending_pixels.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            // results first: an item accepted now cannot already be on the output
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (pending_pixels.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_px = pending_pixels.pop_front();
                    if (exp_px !== i_out_data) begin
                        if (o_errors < 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %p", exp_px);
                            $display("  actual   %p", i_out_data);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                n = cur_width() * cur_height();
                lag = reg_order * cur_width() + reg_order;
                case (i_in_data.opcode)
                    rkcb_pkg::OP_LOAD: begin
                        if (i_in_data.tap_index < TAPS)
                            coef[i_in_data.tap_index] = i_in_data.tap_value;
                    end
                    rkcb_pkg::OP_PIXEL: begin
                        if (in_pos < n) begin
                            pixel_lines[in_pos % LINE_DEPTH] =
                                {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
                            in_pos++;
                            if (out_pos < n && in_pos - 1 >= out_pos + lag)
                                pending_pixels.push_back(filter_pixel());
                        end
                    end
                    rkcb_pkg::OP_FLUSH: begin
                        if (in_pos >= n && out_pos < n)
                            pending_pixels.push_back(filter_pixel());
                    end
                    default: ;
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rkcb_pkg::CFG_WIDTH:  reg_width = i_cfg_data[10:0];
                    rkcb_pkg::CFG_HEIGHT: reg_height = i_cfg_data[12:0];
                    rkcb_pkg::CFG_ORDER:  reg_order = i_cfg_data[1:0];
                    rkcb_pkg::CFG_KSUM:   reg_ksum = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index != rkcb_pkg::CFG_KSUM) begin
                    in_pos = 0;
                    out_pos = 0;
                end
            end
        end
    end

endmodule

>>> bench/tb_rgb_kernel_convolution_border_renorm_unit.sv
// top of the convolution testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_rgb_kernel_convolution_border_renorm_unit;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    rkcb_pkg::t_in_item  i_in_data;
    logic                o_in_stall;
    logic                o_out_valid;
    rkcb_pkg::t_out_item o_out_data;
    logic                i_out_stall;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    int errors, pending, results;
    int items_sent = 0;
    int frames_run = 0;
    bit calm = 0;       // no idling in the closing stretch
    bit long_hold = 0;  // request for one long receiver hold-off
    logic signed [23:0] taps_now [49];

    always #5 i_clk = ~i_clk;

    rgb_kernel_convolution_border_renorm_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    rkcb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // receiver side: random stall bursts, one long hold when asked
    initial begin
        forever begin
            if (long_hold) begin
                long_hold = 0;
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // valid stays high between back-to-back items, dropped only for a gap
    task automatic send(input logic [1:0] op, input logic [5:0] idx,
                        input logic [23:0] val, input logic [47:0] rgb);
        rkcb_pkg::t_in_item it;
        int gap;
        it.opcode = op;
        it.tap_index = idx;
        it.tap_value = val;
        {it.in_red, it.in_green, it.in_blue} = rgb;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == rkcb_pkg::OP_LOAD && idx < 49) taps_now[idx] = val;
        items_sent++;
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [47:0] rand_rgb();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    function automatic logic [23:0] rand_tap();
        case ($urandom_range(0, 5))
            0: return 24'($urandom());
            1: return 24'h7fffff;
            2: return 24'h800000;
            default: return 24'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    // sender pauses until every result is out, then lets the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic configure(input int w, input int h, input int o, input logic [31:0] ks);
        logic [31:0] vals [4];
        wait_idle();
        vals = '{w, h, o, ks};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= k[1:0];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // tap sum over the current kernel side, a natural choice of full divisor
    function automatic logic [31:0] tap_total(input int o);
        longint s;
        int side;
        s = 0;
        side = 2 * o + 1;
        for (int k = 0; k < side * side; k++) s += taps_now[k];
        return s[31:0];
    endfunction

    // one frame: taps, pixels with optional noise, ignored extras, then flushes
    task automatic run_frame(input int w, input int h, input int o, input bit noisy);
        int ew, eh, n, lag, drain;
        logic [31:0] ks;
        ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
        eh = (h == 0) ? 1 : (h > 4096 ? 4096 : h);
        n = ew * eh;
        lag = o * ew + o;
        for (int k = 0; k < (2 * o + 1) * (2 * o + 1); k++)
            if ($urandom_range(0, 3) != 0) send(rkcb_pkg::OP_LOAD, 6'(k), rand_tap(), 48'h0);
        case ($urandom_range(0, 5))
            0: ks = 32'h0;
            1: ks = $urandom();
            2: ks = -tap_total(o);
            default: ks = tap_total(o);
        endcase
        configure(w, h, o, ks);
        for (int p = 0; p < n; p++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: send(rkcb_pkg::OP_SPARE, 6'($urandom()), 24'($urandom()), rand_rgb());
                    1: send(rkcb_pkg::OP_FLUSH, 6'($urandom()), 24'($urandom()), rand_rgb());
                    default: send(rkcb_pkg::OP_LOAD, 6'($urandom_range(0, 63)), rand_tap(),
                                  rand_rgb());
                endcase
            end
            send(rkcb_pkg::OP_PIXEL, 6'($urandom()), 24'($urandom()), rand_rgb());
        end
        if (noisy) repeat ($urandom_range(0, 2))
            send(rkcb_pkg::OP_PIXEL, 6'($urandom()), 24'($urandom()), rand_rgb());
        drain = (n < lag ? n : lag) + (noisy ? $urandom_range(0, 2) : 0);
        repeat (drain) send(rkcb_pkg::OP_FLUSH, 6'($urandom()), 24'($urandom()), rand_rgb());
        frames_run++;
    endtask

    initial begin
        foreach (taps_now[k]) taps_now[k] = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= rkcb_pkg::CFG_WIDTH;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 image, 3x3 kernel, extremes of pixels and taps
        send(rkcb_pkg::OP_FLUSH, 6'd0, 24'd0, 48'h0);          // flush with nothing pending
        send(rkcb_pkg::OP_SPARE, 6'h3f, 24'hffffff, 48'hffff_ffff_ffff);
        send(rkcb_pkg::OP_LOAD, 6'd63, 24'h7fffff, 48'h0);     // tap index beyond the store
        for (int k = 0; k < 9; k++) send(rkcb_pkg::OP_LOAD, 6'(k), 24'd256, 48'h0);
        configure(3, 3, 1, 32'd2304);
        send(rkcb_pkg::OP_PIXEL, 6'd0, 24'd0, 48'h0);
        send(rkcb_pkg::OP_PIXEL, 6'd0, 24'd0, 48'hffff_ffff_ffff);
        send(rkcb_pkg::OP_FLUSH, 6'd0, 24'd0, 48'h0);          // early flush, ignored
        send(rkcb_pkg::OP_LOAD, 6'd4, 24'h800000, 48'h0);      // tap change mid-frame
        repeat (7) send(rkcb_pkg::OP_PIXEL, 6'd0, 24'd0, rand_rgb());
        send(rkcb_pkg::OP_PIXEL, 6'd0, 24'd0, 48'h1234_5678_9abc);  // after frame complete
        repeat (5) send(rkcb_pkg::OP_FLUSH, 6'd0, 24'd0, 48'h0);

        // register extremes: clamped geometry and zero, min, max divisors
        run_frame(0, 0, 0, 0);
        run_frame(1, 1, 3, 0);
        configure(1, 8191, 0, 32'h8000_0000);
        repeat (6) send(rkcb_pkg::OP_PIXEL, 6'd0, 24'd0, rand_rgb());
        configure(2047, 1, 0, 32'h7fff_ffff);
        repeat (4) send(rkcb_pkg::OP_PIXEL, 6'd0, 24'd0, rand_rgb());
        run_frame(1024, 1, 0, 0);
        run_frame(4, 3, 3, 1);

        // random frames, with one long output hold-off filling the block
        while (items_sent < 1600) begin
            if (items_sent > 1450) calm = 1;
            if (frames_run == 6) long_hold = 1;
            run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 3),
                      $urandom_range(0, 3) != 0);
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        $display("covered %0d input items over %0d frames, %0d filtered pixels checked",
                 items_sent, frames_run, results);
        $display("geometry from 1x1 to 1024 wide, kernel orders 0 to 3, divisors zero to extremes");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
